// ===== rtl/euclidean_distance_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef EUCLIDEAN_DISTANCE_MACROS_SVH
`define EUCLIDEAN_DISTANCE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define ED_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ed assertion failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define ED_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ed assertion failed");

`endif

// ===== rtl/ed_pkg.sv =====
package ed_pkg;

  // Fixed field widths
  localparam int ELEM_W   = 16;
  localparam int DIST_W   = 21;
  localparam int SUM_BITS = 42;
  // Widest element the sign extension supports
  localparam int RAW_W    = 32;

  // Parameter defaults
  localparam int MAX_DIM_DEFAULT   = 1024;
  localparam int ELEM_BITS_DEFAULT = 16;

  localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

  // Input beat
  typedef struct packed {
    logic signed [ELEM_W-1:0] elem_u;
    logic signed [ELEM_W-1:0] elem_v;
    logic                     last;
  } elem_t;

  // Result beat
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              saturated;
  } result_t;

endpackage

// ===== rtl/ed_isqrt.sv =====
module ed_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ed_pkg::SUM_BITS-1:0] operand,
  output logic                        busy,
  output logic [ed_pkg::DIST_W-1:0]   root_out
);
  import ed_pkg::*;

  localparam logic [SUM_BITS-1:0] BIT_INIT = SUM_BITS'(1) << (SUM_BITS - 2);

  logic [SUM_BITS-1:0] rem;
  logic [SUM_BITS-1:0] root;
  logic [SUM_BITS-1:0] bit_q;
  logic [SUM_BITS:0]   trial;
  logic                take;

  // One digit per cycle: compare remainder against root + bit
  always_comb begin
    trial = {1'b0, root} + {1'b0, bit_q};
    take  = ({1'b0, rem} >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy  <= 1'b1;
      rem   <= operand;
      root  <= '0;
      bit_q <= BIT_INIT;
    end else if (busy) begin
      if (take) begin
        rem  <= rem - trial[SUM_BITS-1:0];
        root <= (root >> 1) + bit_q;
      end else begin
        root <= root >> 1;
      end
      bit_q <= bit_q >> 2;
      // last digit done when the bit reaches the lsb
      if (bit_q[0]) begin
        busy <= 1'b0;
      end
    end
  end

  assign root_out = root[DIST_W-1:0];

endmodule

// ===== rtl/euclidean_distance.sv =====
// Euclidean (L2) distance of two vectors streamed one element pair per beat.
// Input channel elem (elem_valid/elem_ready): elem_u and elem_v in signed
// Q8.8, last marks the final pair. Output channel result (result_valid/
// result_ready): distance in unsigned Q13.8 and a saturated flag, one beat
// per vector, given on the pair marked last.
// Each pair is squared by a shift-add loop that feeds one saturating 42-bit
// adder, one multiplier bit per cycle, stopping at the top set bit of
// |u - v|; a pair past MAX_DIM skips the loop. On the last pair the 21-step
// digit-by-digit square root runs after that, and the result moves into the
// output register once it is free. elem_ready is high only while the
// sequencer is idle.
// The result sits in an output register: while the receiver stalls, new
// pairs of the next vector are still taken; only a finished root waits for
// the register to free up. Reset (rst, synchronous) clears the sum, the
// element count, the overflow flag and any pending result.
module euclidean_distance #(
  parameter int MAX_DIM   = ed_pkg::MAX_DIM_DEFAULT,
  parameter int ELEM_BITS = ed_pkg::ELEM_BITS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            elem_valid,
  output logic            elem_ready,
  input  ed_pkg::elem_t   elem,
  output logic            result_valid,
  input  logic            result_ready,
  output ed_pkg::result_t result
);
  import ed_pkg::*;

  localparam int MAG_BITS = ELEM_BITS + 1;
  localparam int TERM_W   = (2 * MAG_BITS > SUM_BITS) ? 2 * MAG_BITS : SUM_BITS;
  localparam int CNT_W    = $clog2(MAX_DIM + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_START,
    S_WAIT
  } state_t;

  state_t              state;
  logic [SUM_BITS-1:0] square_sum;
  logic [CNT_W-1:0]    element_count;
  logic                overflow_seen;
  logic [MAG_BITS-1:0] mplier;
  logic [TERM_W-1:0]   mcand;
  logic                last_q;

  logic [RAW_W-1:0]     raw_u;
  logic [RAW_W-1:0]     raw_v;
  logic [ELEM_BITS-1:0] u_e;
  logic [ELEM_BITS-1:0] v_e;
  logic [MAG_BITS-1:0]  diff;
  logic [MAG_BITS-1:0]  mag;
  logic                 count_full;
  logic                 term_big;
  logic [SUM_BITS:0]    acc_sum;
  logic                 acc_ovf;
  logic                 accept;
  logic                 sqrt_start;
  logic                 sqrt_busy;
  logic [DIST_W-1:0]    sqrt_root;
  logic                 res_load;

  // Element decode: sign-extend from ELEM_BITS, take |u - v|
  always_comb begin
    raw_u      = RAW_W'($unsigned(elem.elem_u));
    raw_v      = RAW_W'($unsigned(elem.elem_v));
    u_e        = raw_u[ELEM_BITS-1:0];
    v_e        = raw_v[ELEM_BITS-1:0];
    diff       = {u_e[ELEM_BITS-1], u_e} - {v_e[ELEM_BITS-1], v_e};
    mag        = diff[MAG_BITS-1] ? MAG_BITS'(~diff + MAG_BITS'(1)) : diff;
    count_full = (element_count >= CNT_W'(MAX_DIM));
  end

  // Shared saturating accumulate of one partial product
  always_comb begin
    term_big = (mcand > TERM_W'(SUM_MAX));
    acc_sum  = {1'b0, square_sum} + {1'b0, mcand[SUM_BITS-1:0]};
    acc_ovf  = term_big || acc_sum[SUM_BITS];
  end

  assign elem_ready = (state == S_IDLE);
  assign accept     = elem_valid && elem_ready;
  assign sqrt_start = (state == S_START);
  // finished root moves into a free (or freeing) output register
  assign res_load   = (state == S_WAIT) && !sqrt_busy && (!result_valid || result_ready);

  ed_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .operand  (square_sum),
    .busy     (sqrt_busy),
    .root_out (sqrt_root)
  );

  // Sequencer, accumulator and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      square_sum    <= '0;
      element_count <= '0;
      overflow_seen <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (res_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            last_q <= elem.last;
            if (count_full) begin
              // too many pairs: force the sum to full scale
              square_sum    <= SUM_MAX;
              overflow_seen <= 1'b1;
              state         <= elem.last ? S_START : S_IDLE;
            end else begin
              element_count <= element_count + CNT_W'(1);
              mplier        <= mag;
              mcand         <= TERM_W'(mag);
              state         <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (mplier == '0) begin
            state <= last_q ? S_START : S_IDLE;
          end else begin
            if (mplier[0]) begin
              if (acc_ovf) begin
                square_sum    <= SUM_MAX;
                overflow_seen <= 1'b1;
              end else begin
                square_sum <= acc_sum[SUM_BITS-1:0];
              end
            end
            mplier <= mplier >> 1;
            mcand  <= mcand << 1;
          end
        end
        S_START: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (res_load) begin
            result.distance  <= sqrt_root;
            result.saturated <= overflow_seen;
            square_sum       <= '0;
            element_count    <= '0;
            overflow_seen    <= 1'b0;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/ed_checker.sv =====
`include "euclidean_distance_macros.svh"

module ed_checker (
  input logic            clk,
  input logic            rst,
  input logic            elem_valid,
  input logic            elem_ready,
  input ed_pkg::elem_t   elem,
  input logic            result_valid,
  input logic            result_ready,
  input ed_pkg::result_t result
);
  import ed_pkg::*;

  // Result beat holds while stalled
  `ED_ASSERT_NEXT(a_res_valid_hold, result_valid && !result_ready, result_valid)
  `ED_ASSERT_NEXT(a_res_data_hold, result_valid && !result_ready, $stable(result))

  // A pair not marked last never yields a new result right after it
  `ED_ASSERT_NEXT(a_no_res_mid, elem_valid && elem_ready && !elem.last, !$rose(result_valid))

  // The last pair always sends the sequencer busy
  `ED_ASSERT_NEXT(a_busy_after_last, elem_valid && elem_ready && elem.last, !elem_ready)

  // A saturated sum always reads as full-scale distance
  `ED_ASSERT_SAME(a_sat_full, result_valid && result.saturated, result.distance == '1)

endmodule

bind euclidean_distance ed_checker u_ed_checker (.*);
